// ----- rtl/bile_pkg.sv -----
// Shared types, constants and address helpers for the bounded integer list engine.
// Depends on nothing; imported by bile_core and bounded_int_list_engine_unit.
package bile_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SUM_W    = IDX_W + 1;
    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int STAT_W   = 2;
    localparam int ENTRY_W  = 5;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [DATA_W-1:0] t_data;

    typedef enum logic [OP_W-1:0] {
        OP_ADD_HEAD = 3'd0,
        OP_ADD_TAIL = 3'd1,
        OP_POP_HEAD = 3'd2,
        OP_POP_TAIL = 3'd3,
        OP_DELETE   = 3'd4,
        OP_CONTAINS = 3'd5,
        OP_CLEAR    = 3'd6,
        OP_PEEK     = 3'd7
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } t_state;

    typedef struct packed {
        t_status              status;
        t_data                value;
        logic [ENTRY_W-1:0]   count;
    } t_result;

    // Circular buffer index arithmetic; every result is an index below CAPACITY.
    function automatic t_idx wrap_inc(input t_idx a);
        t_idx r;
        if (a == t_idx'(CAPACITY - 1)) r = '0;
        else                           r = a + t_idx'(1);
        return r;
    endfunction

    function automatic t_idx wrap_dec(input t_idx a);
        t_idx r;
        if (a == '0) r = t_idx'(CAPACITY - 1);
        else         r = a - t_idx'(1);
        return r;
    endfunction

    function automatic t_idx wrap_add(input t_idx a, input t_cnt b);
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b);
        if (s >= SUM_W'(CAPACITY)) s = s - SUM_W'(CAPACITY);
        return s[IDX_W-1:0];
    endfunction

endpackage

// ----- rtl/bile_core.sv -----
// List storage (circular buffer memory) and the sequencer that walks it one entry a cycle.
// Depends on bile_pkg.
module bile_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  bile_pkg::t_op      i_op,
    input  bile_pkg::t_data    i_value,
    output logic               o_idle,
    output logic               o_res_valid,
    input  logic               i_res_take,
    output bile_pkg::t_result  o_res
);
    import bile_pkg::*;

    t_data   r_mem [CAPACITY];
    t_data   r_rdata;

    t_state  r_state, n_state;
    t_op     r_op, n_op;
    t_data   r_value, n_value;
    t_idx    r_head, n_head;
    t_cnt    r_count, n_count;
    t_cnt    r_idx, n_idx;
    t_idx    r_ptr, n_ptr;
    t_idx    r_rptr, n_rptr;
    t_status r_status, n_status;
    t_data   r_rv, n_rv;

    logic    mem_we;
    t_idx    mem_waddr;
    t_data   mem_wdata;
    logic    mem_re;
    t_idx    mem_raddr;

    t_cnt    addr_off;
    t_idx    addr_sum;
    t_idx    rptr_inc;
    logic    is_full;
    logic    is_empty;
    logic    more;
    logic    hit;

    assign is_full  = (r_count == t_cnt'(CAPACITY));
    assign is_empty = (r_count == '0);
    assign rptr_inc = wrap_inc(r_rptr);
    assign more     = ((r_idx + t_cnt'(1)) < r_count);
    assign hit      = (r_rdata == r_value);

    // Shared address adder: tail slot for appends, last entry for tail pops, head entry for all other ops.
    always_comb begin
        unique case (i_op)
            OP_ADD_TAIL: addr_off = r_count;
            OP_POP_TAIL: addr_off = r_count - t_cnt'(1);
            default:     addr_off = '0;
        endcase
        addr_sum = wrap_add(r_head, addr_off);
    end

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_value   = r_value;
        n_head    = r_head;
        n_count   = r_count;
        n_idx     = r_idx;
        n_ptr     = r_ptr;
        n_rptr    = r_rptr;
        n_status  = r_status;
        n_rv      = r_rv;
        mem_we    = 1'b0;
        mem_waddr = addr_sum;
        mem_wdata = i_value;
        mem_re    = 1'b0;
        mem_raddr = addr_sum;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op     = i_op;
                    n_value  = i_value;
                    n_status = ST_OK;
                    n_rv     = '0;
                    n_idx    = '0;
                    n_rptr   = addr_sum;
                    n_state  = S_DONE;
                    unique case (i_op)
                        OP_ADD_HEAD: begin
                            if (is_full) begin
                                n_status = ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = wrap_dec(r_head);
                                n_head    = wrap_dec(r_head);
                                n_count   = r_count + t_cnt'(1);
                            end
                        end
                        OP_ADD_TAIL: begin
                            if (is_full) begin
                                n_status = ST_FULL;
                            end else begin
                                mem_we  = 1'b1;
                                n_count = r_count + t_cnt'(1);
                            end
                        end
                        OP_POP_HEAD, OP_POP_TAIL, OP_PEEK: begin
                            if (is_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                mem_re  = 1'b1;
                                n_state = S_READ;
                            end
                        end
                        OP_DELETE, OP_CONTAINS: begin
                            if (is_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                mem_re  = 1'b1;
                                n_state = S_SCAN;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                n_rv    = r_rdata;
                n_state = S_DONE;
                if (r_op == OP_POP_HEAD) begin
                    n_head  = wrap_inc(r_head);
                    n_count = r_count - t_cnt'(1);
                end else if (r_op == OP_POP_TAIL) begin
                    n_count = r_count - t_cnt'(1);
                end
            end
            S_SCAN: begin
                mem_raddr = rptr_inc;
                if (hit) begin
                    n_rv = r_value;
                    if (r_op == OP_CONTAINS) begin
                        n_state = S_DONE;
                    end else if (more) begin
                        // hold the slot to fill, fetch its successor
                        mem_re  = 1'b1;
                        n_ptr   = r_rptr;
                        n_rptr  = rptr_inc;
                        n_idx   = r_idx + t_cnt'(1);
                        n_state = S_SHIFT;
                    end else begin
                        n_count = r_count - t_cnt'(1);
                        n_state = S_DONE;
                    end
                end else if (more) begin
                    mem_re = 1'b1;
                    n_rptr = rptr_inc;
                    n_idx  = r_idx + t_cnt'(1);
                end else begin
                    n_status = ST_NOTFOUND;
                    n_state  = S_DONE;
                end
            end
            S_SHIFT: begin
                // move the fetched entry one place towards the head
                mem_we    = 1'b1;
                mem_waddr = r_ptr;
                mem_wdata = r_rdata;
                mem_raddr = rptr_inc;
                n_ptr     = r_rptr;
                if (more) begin
                    mem_re = 1'b1;
                    n_rptr = rptr_inc;
                    n_idx  = r_idx + t_cnt'(1);
                end else begin
                    n_count = r_count - t_cnt'(1);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_take) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_value  <= n_value;
        r_idx    <= n_idx;
        r_ptr    <= n_ptr;
        r_rptr   <= n_rptr;
        r_status <= n_status;
        r_rv     <= n_rv;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_rdata <= r_mem[mem_raddr];
    end

    assign o_idle        = (r_state == S_IDLE);
    assign o_res_valid   = (r_state == S_DONE);
    assign o_res.status  = r_status;
    assign o_res.value   = r_rv;
    assign o_res.count   = ENTRY_W'(r_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_cnt'(CAPACITY))
        else $error("occupancy above capacity");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && r_state == S_IDLE && i_op == OP_CLEAR) |=> (r_count == '0))
        else $error("clear left entries behind");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_SHIFT) |-> (r_idx < r_count))
        else $error("walk past the last entry");

    a_shift_not_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_idx != '0 && r_op == OP_DELETE))
        else $error("shift outside a delete");

    a_full_only_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_status == ST_FULL)
            |-> (r_op == OP_ADD_HEAD || r_op == OP_ADD_TAIL))
        else $error("full status on a non-insert");

endmodule

// ----- rtl/bounded_int_list_engine_unit.sv -----
// Bounded list engine top level: input handshake, bile_core and the result register.
// Inserts, clear and ops that fail on an empty or full list pass from idle straight to the
// done state in bile_core; pops and peek read one entry first; contains and delete walk up to
// the entries held beforehand, one entry read, compared or moved per cycle in bile_core.
// One item at a time: o_ready returns once the result moves to the output register, so no new
// item is taken while another is in progress or its result waits in bile_core.
// Reset (synchronous, active low) empties the list; stored entries are not cleared.
module bounded_int_list_engine_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [bile_pkg::OP_W-1:0]           i_op,
    input  logic signed [bile_pkg::DATA_W-1:0]  i_value,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [bile_pkg::STAT_W-1:0]         o_status,
    output logic signed [bile_pkg::DATA_W-1:0]  o_result_value,
    output logic [bile_pkg::ENTRY_W-1:0]        o_entry_count
);
    import bile_pkg::*;

    logic    core_idle;
    logic    core_res_valid;
    logic    core_take;
    t_result core_res;

    logic    r_out_valid, n_out_valid;
    t_result r_out;

    // load a fresh result whenever the output slot is free or being drained
    assign core_take   = core_res_valid && (!r_out_valid || i_ready);
    assign n_out_valid = core_take || (r_out_valid && !i_ready);

    bile_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_valid && core_idle),
        .i_op        (t_op'(i_op)),
        .i_value     (t_data'(i_value)),
        .o_idle      (core_idle),
        .o_res_valid (core_res_valid),
        .i_res_take  (core_take),
        .o_res       (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_take) r_out <= core_res;
    end

    assign o_ready        = core_idle;
    assign o_valid        = r_out_valid;
    assign o_status       = r_out.status;
    assign o_result_value = r_out.value;
    assign o_entry_count  = r_out.count;

endmodule
